### sv/rc_control_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// rc_control_frame_parser assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RC_CONTROL_FRAME_PARSER_MACROS_SVH
`define RC_CONTROL_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define RCFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcfp assertion failed");

// next-cycle implication
`define RCFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcfp assertion failed");

`endif

### sv/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Types and constants of the control frame parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  localparam int unsigned BodyLen = 13;
  localparam int unsigned BodyIdxW = 4;
  localparam int unsigned PosW = 5;

  localparam logic [PosW-1:0] POS_HDR0       = 5'd0;
  localparam logic [PosW-1:0] POS_HDR1       = 5'd1;
  localparam logic [PosW-1:0] POS_BODY_FIRST = 5'd2;
  localparam logic [PosW-1:0] POS_BODY_LAST  = 5'd14;
  localparam logic [PosW-1:0] POS_CHECKSUM   = 5'd15;
  localparam logic [PosW-1:0] POS_CR         = 5'd16;
  localparam logic [PosW-1:0] POS_LF         = 5'd17;
  localparam logic [PosW-1:0] POS_IDLE       = 5'd18;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'd170;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'd85;

  localparam logic [7:0]  STICK_SCALE  = 8'd200;
  localparam logic [7:0]  STICK_OFFSET = 8'd100;
  localparam int unsigned DivShift     = 12;
  localparam logic [12:0] STICK_DIV    = 13'd4095;
  localparam logic [11:0] KNOB_MAX     = 12'd1023;

  // configuration register indexes
  localparam logic CFG_HEADER_FIRST  = 1'b0;
  localparam logic CFG_HEADER_SECOND = 1'b1;

  typedef logic [BodyLen-1:0][7:0] rcfp_body_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } rcfp_in_t;

  typedef struct packed {
    logic signed [7:0] left_stick_x;
    logic signed [7:0] left_stick_y;
    logic signed [7:0] right_stick_x;
    logic signed [7:0] right_stick_y;
    logic [9:0]        left_knob;
    logic [9:0]        right_knob;
    logic [7:0]        switch_bits;
    logic [11:0]       raw_left_x;
    logic [11:0]       raw_left_y;
    logic [11:0]       raw_right_x;
    logic [11:0]       raw_right_y;
  } rcfp_out_t;

  typedef struct packed {
    logic frame_done;
    logic at_last;
  } rcfp_stat_t;

endpackage

### sv/rcfp_collect.sv
// ----------------------------------------------------------------------------
// rcfp_collect
// Tracks byte position, checksum and checks; stores frame body bytes.
// ----------------------------------------------------------------------------
`include "rc_control_frame_parser_macros.svh"

module rcfp_collect
  import rcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  rcfp_in_t   in_req,
  input  logic [7:0] header_first,
  input  logic [7:0] header_second,
  output rcfp_body_t body,
  output rcfp_stat_t stat
);

  logic [PosW-1:0]     pos_r, pos_nxt, eff_pos;
  logic [7:0]          sum_r, sum_nxt;
  logic                ok_r, ok_nxt;
  logic                active;
  logic                body_wr;
  logic [PosW-1:0]     body_off;
  logic [BodyIdxW-1:0] body_idx;
  rcfp_body_t          body_r;

  assign eff_pos  = in_req.first_byte ? POS_HDR0 : pos_r;
  assign active   = eff_pos < POS_IDLE;
  assign body_off = eff_pos - POS_BODY_FIRST;
  assign body_idx = body_off[BodyIdxW-1:0];

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    ok_nxt  = ok_r;
    body_wr = 1'b0;
    if (accept && active) begin
      pos_nxt = eff_pos + 5'd1;
      unique case (eff_pos) inside
        POS_HDR0: begin
          sum_nxt = 8'd0;
          ok_nxt  = (in_req.data_byte == header_first);
        end
        POS_HDR1:     ok_nxt = ok_r && (in_req.data_byte == header_second);
        [POS_BODY_FIRST:POS_BODY_LAST]: begin
          body_wr = 1'b1;
          sum_nxt = sum_r + in_req.data_byte;
        end
        POS_CHECKSUM: ok_nxt = ok_r && (in_req.data_byte == sum_r);
        POS_CR:       ok_nxt = ok_r && (in_req.data_byte == BYTE_CR);
        POS_LF:       ok_nxt = ok_r && (in_req.data_byte == BYTE_LF);
        default:      ok_nxt = ok_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
      sum_r <= 8'd0;
      ok_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      ok_r  <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BodyLen; i++) begin
      if (body_wr && (body_idx == BodyIdxW'(i))) begin
        body_r[i] <= in_req.data_byte;
      end
    end
  end

  assign body            = body_r;
  assign stat.at_last    = (pos_r == POS_LF);
  assign stat.frame_done = accept && (eff_pos == POS_LF) && ok_nxt;

  `RCFP_ASSERT_IMP(a_pos_range, 1'b1, pos_r <= POS_IDLE)
  `RCFP_ASSERT_NXT(a_restart, accept && in_req.first_byte, pos_r == POS_HDR1)
  `RCFP_ASSERT_IMP(a_done_ok, stat.frame_done, ok_r && !in_req.first_byte)

endmodule

### sv/rcfp_stick.sv
// ----------------------------------------------------------------------------
// rcfp_stick
// Scales a 12-bit stick value to signed percent: raw*200/4095 - 100.
// ----------------------------------------------------------------------------
module rcfp_stick
  import rcfp_pkg::*;
(
  input  logic [11:0]       raw,
  output logic signed [7:0] pct
);

  logic [19:0] prod;
  logic [7:0]  q_est;
  logic [12:0] rem_est;
  logic [7:0]  quot;

  // 4095 = 2^12 - 1: estimate by shift, then one correction step
  assign prod    = 20'(raw) * 20'(STICK_SCALE);
  assign q_est   = prod[19:DivShift];
  assign rem_est = 13'(prod[DivShift-1:0]) + 13'(q_est);
  assign quot    = q_est + 8'(rem_est >= STICK_DIV);
  assign pct     = signed'(quot - STICK_OFFSET);

endmodule

### sv/rc_control_frame_parser.sv
// A result is registered into the output register as the frame's last byte is accepted.
// Throughput: one byte per cycle unless in_stall; position and checksum update per byte.
// Input stalls only when a frame's last byte is due while a previous result still waits.
// Reset: synchronous active-low rst_n; headers return to 0xAA/0x55, no frame open,
// output empty. Body storage is not cleared.
// ----------------------------------------------------------------------------
// rc_control_frame_parser
// Validates 18-byte control frames and emits scaled stick and knob values.
// ----------------------------------------------------------------------------
`include "rc_control_frame_parser_macros.svh"

module rc_control_frame_parser
  import rcfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rcfp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rcfp_out_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic       [7:0] hdr_first_r, hdr_second_r;
  logic             in_accept;
  rcfp_body_t       body;
  rcfp_stat_t       stat;
  rcfp_out_t        res;
  logic [11:0]      lx, ly, rx, ry, lk, rk;
  logic             out_valid_r, out_valid_nxt;
  rcfp_out_t        out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HEADER_FIRST_RST;
      hdr_second_r <= HEADER_SECOND_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  hdr_first_r  <= cfg_wdata;
        CFG_HEADER_SECOND: hdr_second_r <= cfg_wdata;
        default:           hdr_first_r  <= hdr_first_r;
      endcase
    end
  end

  assign in_stall  = out_valid_r && out_stall && stat.at_last;
  assign in_accept = in_valid && !in_stall;

  rcfp_collect u_collect (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .in_req        (in_data),
    .header_first  (hdr_first_r),
    .header_second (hdr_second_r),
    .body          (body),
    .stat          (stat)
  );

  assign lx = {body[1][3:0], body[0]};
  assign ly = {body[3][3:0], body[2]};
  assign rx = {body[5][3:0], body[4]};
  assign ry = {body[7][3:0], body[6]};
  assign lk = {body[9][3:0], body[8]};
  assign rk = {body[11][3:0], body[10]};

  rcfp_stick u_stick_lx (.raw(lx), .pct(res.left_stick_x));
  rcfp_stick u_stick_ly (.raw(ly), .pct(res.left_stick_y));
  rcfp_stick u_stick_rx (.raw(rx), .pct(res.right_stick_x));
  rcfp_stick u_stick_ry (.raw(ry), .pct(res.right_stick_y));

  assign res.left_knob   = (lk > KNOB_MAX) ? KNOB_MAX[9:0] : lk[9:0];
  assign res.right_knob  = (rk > KNOB_MAX) ? KNOB_MAX[9:0] : rk[9:0];
  assign res.switch_bits = body[12];
  assign res.raw_left_x  = lx;
  assign res.raw_left_y  = ly;
  assign res.raw_right_x = rx;
  assign res.raw_right_y = ry;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.frame_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.frame_done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RCFP_ASSERT_IMP(a_no_overwrite, stat.frame_done, !(out_valid_r && out_stall))
  `RCFP_ASSERT_NXT(a_done_shows, stat.frame_done, out_valid)
  `RCFP_ASSERT_IMP(a_stall_cause, in_stall, out_valid && stat.at_last)

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for rc_control_frame_parser
// Sends remote-control byte frames (good, corrupted, truncated and noise)
// under several header settings, with random sender gaps and output stalls.
// A local frame decoder predicts each decoded result, and the monitor
// compares every result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import rcfp_pkg::*;

  localparam int IdleLimit  = 1000;
  localparam int TailCycles = 4;
  localparam int PhaseBytes = 125;
  localparam int PhaseGood  = 5;
  localparam int NumPhases  = 5;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_HDR0,
    FRM_BAD_HDR1,
    FRM_BAD_SUM,
    FRM_BAD_CR,
    FRM_BAD_LF,
    FRM_SHORT
  } frame_kind_e;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  rcfp_in_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rcfp_out_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_index = CFG_HEADER_FIRST;
  logic [7:0] cfg_wdata = '0;

  rc_control_frame_parser dut (.*);

  rcfp_in_t   req_q[$];
  rcfp_out_t  expected_frames[$];

  logic [7:0] hdr_first  = HEADER_FIRST_RST;
  logic [7:0] hdr_second = HEADER_SECOND_RST;
  logic [4:0] frm_pos    = POS_IDLE;
  logic [7:0] frm_sum    = '0;
  logic       frm_ok     = 1'b0;
  logic [7:0] frm_body [BodyLen];

  bit in_taken;
  int send_left, gap_left, free_left, stall_left;
  int idle_cycles, mismatches, bytes_taken, results_seen;
  int stim_bytes, good_frames, phases_run;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [7:0] stick_pct(logic [11:0] raw);
    int pct;
    pct = (int'(raw) * 200) / 4095 - 100;
    return pct[7:0];
  endfunction

  function automatic logic [9:0] knob_clamp(logic [11:0] raw);
    return (raw > 12'd1023) ? 10'd1023 : raw[9:0];
  endfunction

  function automatic void decode_byte(rcfp_in_t r);
    logic [4:0]  at;
    logic [11:0] raw [6];
    rcfp_out_t   res;
    if (r.first_byte) frm_pos = POS_HDR0;
    if (frm_pos >= POS_IDLE) return;
    at = frm_pos;
    frm_pos = at + 5'd1;
    if (at == POS_HDR0) begin
      frm_sum = '0;
      frm_ok = (r.data_byte == hdr_first);
    end else if (at == POS_HDR1) begin
      frm_ok = frm_ok && (r.data_byte == hdr_second);
    end else if (at <= POS_BODY_LAST) begin
      frm_body[4'(at - POS_BODY_FIRST)] = r.data_byte;
      frm_sum = frm_sum + r.data_byte;
    end else if (at == POS_CHECKSUM) begin
      frm_ok = frm_ok && (r.data_byte == frm_sum);
    end else if (at == POS_CR) begin
      frm_ok = frm_ok && (r.data_byte == BYTE_CR);
    end else begin
      frm_ok = frm_ok && (r.data_byte == BYTE_LF);
      if (frm_ok) begin
        foreach (raw[k]) raw[k] = {frm_body[2*k+1][3:0], frm_body[2*k]};
        res.left_stick_x  = stick_pct(raw[0]);
        res.left_stick_y  = stick_pct(raw[1]);
        res.right_stick_x = stick_pct(raw[2]);
        res.right_stick_y = stick_pct(raw[3]);
        res.left_knob     = knob_clamp(raw[4]);
        res.right_knob    = knob_clamp(raw[5]);
        res.switch_bits   = frm_body[12];
        res.raw_left_x    = raw[0];
        res.raw_left_y    = raw[1];
        res.raw_right_x   = raw[2];
        res.raw_right_y   = raw[3];
        expected_frames.push_back(res);
      end
    end
  endfunction

  function automatic string fmt_result(rcfp_out_t r);
    return $sformatf("sticks %0d/%0d/%0d/%0d knobs %0d/%0d sw %02h raw %03h/%03h/%03h/%03h",
                     r.left_stick_x, r.left_stick_y, r.right_stick_x, r.right_stick_y,
                     r.left_knob, r.right_knob, r.switch_bits,
                     r.raw_left_x, r.raw_left_y, r.raw_right_x, r.raw_right_y);
  endfunction

  // monitor, checker and watchdog
  always @(posedge clk) begin
    rcfp_out_t want;
    bit        out_taken;
    in_taken = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (out_taken) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        $display("%0t: result with no frame pending, expected none, actual %s",
                 $time, fmt_result(out_data));
      end else begin
        want = expected_frames.pop_front();
        if (out_data !== want) begin
          mismatches++;
          $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                   $time, fmt_result(want), fmt_result(out_data));
        end
      end
    end
    if (in_taken) begin
      bytes_taken++;
      decode_byte(in_data);
    end
    if (in_taken || out_taken) idle_cycles = 0;
    else if (rst_n) idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: nothing moved for %0d cycles", $time, IdleLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // request driver: bursts of random length with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_left == 0 && gap_left == 0) begin
        send_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (send_left > 0 && req_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= req_q.pop_front();
        send_left--;
      end else begin
        in_valid <= 1'b0;
        if (send_left == 0) gap_left--;
      end
    end
  end

  // result back-pressure; long stalls let a finished frame back up the input
  always @(negedge clk) begin
    if (free_left == 0 && stall_left == 0) begin
      free_left = $urandom_range(1, 24);
      case ($urandom_range(0, 5))
        0, 1:    stall_left = 0;
        5:       stall_left = $urandom_range(20, 30);
        default: stall_left = $urandom_range(1, 6);
      endcase
    end
    if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b1;
      stall_left--;
    end
  end

  task automatic queue_req(logic [7:0] b, logic first, bit counted);
    req_q.push_back('{data_byte: b, first_byte: first});
    if (counted) stim_bytes++;
  endtask

  task automatic queue_frame(frame_kind_e kind, logic [11:0] vals [6], logic [7:0] sw);
    logic [7:0] fb [18];
    logic [7:0] sum;
    int         len;
    fb[0] = hdr_first;
    fb[1] = hdr_second;
    foreach (vals[k]) begin
      fb[2 + 2*k] = vals[k][7:0];
      fb[3 + 2*k] = {4'($urandom), vals[k][11:8]};
    end
    fb[14] = sw;
    sum = '0;
    for (int i = 2; i <= 14; i++) sum += fb[i];
    fb[15] = sum;
    fb[16] = BYTE_CR;
    fb[17] = BYTE_LF;
    len = 18;
    case (kind)
      FRM_BAD_HDR0: fb[0]  ^= 8'($urandom_range(1, 255));
      FRM_BAD_HDR1: fb[1]  ^= 8'($urandom_range(1, 255));
      FRM_BAD_SUM:  fb[15] ^= 8'($urandom_range(1, 255));
      FRM_BAD_CR:   fb[16] ^= 8'($urandom_range(1, 255));
      FRM_BAD_LF:   fb[17] ^= 8'($urandom_range(1, 255));
      FRM_SHORT:    len = $urandom_range(1, 17);
      default: ;
    endcase
    if (kind == FRM_GOOD) good_frames++;
    for (int i = 0; i < len; i++) queue_req(fb[i], i == 0, 1'b1);
    // trailing bytes past the frame end
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
      queue_req(8'($urandom), 1'b0, 1'b0);
  endtask

  function automatic logic [11:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return 12'd4095;
      2:       return 12'd1023;
      3:       return 12'd1024;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic queue_random();
    logic [11:0] vals [6];
    int          pick;
    foreach (vals[k]) vals[k] = pick_raw();
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      queue_frame(FRM_GOOD, vals, 8'($urandom));
    end else if (pick < 93) begin
      queue_frame(frame_kind_e'($urandom_range(FRM_BAD_HDR0, FRM_SHORT)), vals, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) queue_req(8'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  task automatic cfg_write(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_HEADER_FIRST:  hdr_first = val;
      CFG_HEADER_SECOND: hdr_second = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || in_valid || expected_frames.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  initial begin
    logic [11:0] vals [6];
    int          start_bytes;
    int          start_good;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // stray byte with no frame open, extreme values, trailing and short frame
    queue_req(8'hFF, 1'b0, 1'b1);
    vals = '{12'd0, 12'd4095, 12'd2047, 12'd2048, 12'd4095, 12'd1023};
    queue_frame(FRM_GOOD, vals, 8'hFF);
    queue_req(8'h00, 1'b0, 1'b1);
    queue_frame(FRM_SHORT, vals, 8'h00);
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: begin
          cfg_write(CFG_HEADER_FIRST, 8'h00);
          cfg_write(CFG_HEADER_SECOND, 8'hFF);
        end
        2: begin
          cfg_write(CFG_HEADER_FIRST, 8'hFF);
          cfg_write(CFG_HEADER_SECOND, 8'h00);
        end
        3: begin
          cfg_write(CFG_HEADER_FIRST, 8'($urandom));
          cfg_write(CFG_HEADER_SECOND, 8'($urandom));
        end
        4: begin
          cfg_write(CFG_HEADER_FIRST, HEADER_FIRST_RST);
          cfg_write(CFG_HEADER_SECOND, HEADER_SECOND_RST);
        end
        default: ;
      endcase
      start_bytes = stim_bytes;
      start_good = good_frames;
      while (stim_bytes - start_bytes < PhaseBytes || good_frames - start_good < PhaseGood)
        queue_random();
      wait_idle();
      phases_run++;
    end

    $display("Covered %0d accepted bytes over %0d header settings; %0d decoded frames checked.",
             bytes_taken, phases_run, results_seen);
    $display("Mix: good, bad header, bad checksum, bad terminator, short, noise; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
